/* rtl/core/segment_display_io_board_core_macros.svh */
// Assertion macros shared by the display and I/O core.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SEGMENT_DISPLAY_IO_BOARD_CORE_MACROS_SVH
`define SEGMENT_DISPLAY_IO_BOARD_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Check that prop holds at every clock edge outside reset.
`define SDIO_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that when cond holds, expect holds at the next clock edge.
`define SDIO_ASSERT_NEXT(lbl, clk, rst_n, cond, expect_c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expect_c)) \
        else $error(msg);
`else
`define SDIO_ASSERT(lbl, clk, rst_n, prop, msg)
`define SDIO_ASSERT_NEXT(lbl, clk, rst_n, cond, expect_c, msg)
`endif
`endif

/* rtl/core/sdio_pkg.sv */
// Shared types, codes and tables of the display and I/O core.
// No dependencies; used by every module of the core.
`default_nettype none

package sdio_pkg;

    // Input item kinds
    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_POLL  = 2'd3
    } kind_t;

    // Result event codes
    typedef enum logic [2:0] {
        EV_DIGIT  = 3'd0,
        EV_TONE   = 3'd1,
        EV_LAMPS  = 3'd2,
        EV_SAMPLE = 3'd3,
        EV_LEDS   = 3'd4,
        EV_READ   = 3'd5,
        EV_WAIT   = 3'd6,
        EV_CPU    = 3'd7
    } ev_t;

    // Queued command opcodes
    typedef enum logic [2:0] {
        OP_SINGLE = 3'd0,
        OP_MATCH  = 3'd1,
        OP_SAMPLE = 3'd2,
        OP_TONE   = 3'd3,
        OP_PAIRS  = 3'd4,
        OP_TICK   = 3'd5
    } op_t;

    // Output port numbers
    localparam logic [2:0] PORT_MATCH  = 3'd1;
    localparam logic [2:0] PORT_LATCH  = 3'd2;
    localparam logic [2:0] PORT_STROBE = 3'd3;
    localparam logic [2:0] PORT_BALL   = 3'd4;
    localparam logic [2:0] PORT_AUX5   = 3'd5;
    localparam logic [2:0] PORT_AUX6   = 3'd6;

    // Strobe select codes
    localparam logic [3:0] SEL_SAMPLE = 4'd0;
    localparam logic [3:0] SEL_TONE   = 4'd1;
    localparam logic [3:0] SEL_QUAD   = 4'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT3 = 2'd1;

    localparam logic [7:0] CFG_SLOT2_RST = 8'h08;
    localparam logic [7:0] CFG_SLOT3_RST = 8'h01;

    // Fixed digit positions and values
    localparam logic [5:0] POS_MATCH_ONE  = 6'd40;
    localparam logic [5:0] POS_MATCH_TEN  = 6'd44;
    localparam logic [5:0] POS_MATCH_TEN2 = 6'd45;
    localparam logic [5:0] POS_TICK_HI    = 6'd41;
    localparam logic [5:0] POS_TICK_LO    = 6'd43;
    localparam logic [7:0] SAMPLE_OUTHOLE = 8'd5;
    localparam logic [7:0] SAMPLE_KNOCKER = 8'd6;

    localparam int WAIT_W = 9;

    // One queued unit of work for the back end
    typedef struct packed {
        op_t        op;
        logic [2:0] last_idx;  // index of the final result
        logic [5:0] tag;       // base position, event code or tick phase
        logic [7:0] a;
        logic [7:0] b;
    } cmd_t;

    // BCD to seven segments, bit0 = a ... bit6 = g; non-BCD codes blank
    function automatic logic [7:0] seg7(input logic [3:0] d);
        logic [7:0] r;
        case (d)
            4'd0: r = 8'h3f;
            4'd1: r = 8'h06;
            4'd2: r = 8'h5b;
            4'd3: r = 8'h4f;
            4'd4: r = 8'h66;
            4'd5: r = 8'h6d;
            4'd6: r = 8'h7c;
            4'd7: r = 8'h07;
            4'd8: r = 8'h7f;
            4'd9: r = 8'h67;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // First digit position driven by a digit select
    function automatic logic [5:0] pair_base(input logic [3:0] sel);
        logic [5:0] r;
        case (sel)
            4'd2:  r = 6'd0;
            4'd3:  r = 6'd2;
            4'd4:  r = 6'd4;
            4'd5:  r = 6'd10;
            4'd6:  r = 6'd12;
            4'd7:  r = 6'd20;
            4'd8:  r = 6'd22;
            4'd9:  r = 6'd30;
            4'd10: r = 6'd32;
            4'd11: r = 6'd32;
            default: r = 6'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/sdio_front.sv */
// Front end: accepts bus items, keeps the latches and counters, queues commands.
// Depends on sdio_pkg.
`default_nettype none

module sdio_front #(
    parameter int WAIT_POLLS = 384
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    input  wire logic [1:0]                     s_kind,
    input  wire logic [2:0]                     s_port,
    input  wire logic [7:0]                     s_data,
    input  wire logic [5:0]                     s_switches,
    input  wire logic                           q_full,
    output logic                                s_ready,
    input  wire logic                           cfg_valid,
    input  wire logic [sdio_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                     cfg_data,
    output logic                                push,
    output sdio_pkg::cmd_t                      cmd
);

    localparam logic [sdio_pkg::WAIT_W-1:0] WAIT_LIMIT = sdio_pkg::WAIT_W'(WAIT_POLLS);

    logic [7:0] slot2_reg, slot3_reg;
    logic [7:0] latch_reg, latch_next;
    logic [6:0] match_reg, match_next;
    logic [4:0] ball_reg, ball_next;
    logic [1:0] phase_reg, phase_next;
    logic [sdio_pkg::WAIT_W-1:0] wait_reg, wait_next;
    logic accept;
    logic [3:0] sel;
    logic [7:0] seg_hi;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign sel     = ~s_data[3:0];
    assign seg_hi  = sdio_pkg::seg7(s_data[7:4]);

    always_comb begin
        latch_next   = latch_reg;
        match_next   = match_reg;
        ball_next    = ball_reg;
        phase_next   = phase_reg;
        wait_next    = wait_reg;
        push         = 1'b0;
        cmd.op       = sdio_pkg::OP_SINGLE;
        cmd.last_idx = 3'd0;
        cmd.tag      = 6'd0;
        cmd.a        = 8'd0;
        cmd.b        = 8'd0;
        if (accept) begin
            case (sdio_pkg::kind_t'(s_kind))
                sdio_pkg::KIND_WRITE: begin
                    case (s_port)
                        sdio_pkg::PORT_MATCH: begin
                            push         = 1'b1;
                            cmd.op       = sdio_pkg::OP_MATCH;
                            cmd.last_idx = 3'd2;
                            cmd.a        = s_data;
                            match_next   = seg_hi[6:0];
                            wait_next    = '0;
                        end
                        sdio_pkg::PORT_LATCH: begin
                            latch_next = s_data;
                            wait_next  = '0;
                        end
                        sdio_pkg::PORT_STROBE: begin
                            wait_next = '0;
                            cmd.a     = latch_reg;
                            if (sel == sdio_pkg::SEL_SAMPLE) begin
                                // one result per set trigger bit, none if neither
                                push         = latch_reg[6] || latch_reg[7];
                                cmd.op       = sdio_pkg::OP_SAMPLE;
                                cmd.last_idx = {2'b00, latch_reg[6] && latch_reg[7]};
                            end else if (sel == sdio_pkg::SEL_TONE) begin
                                push         = 1'b1;
                                cmd.op       = sdio_pkg::OP_TONE;
                                cmd.last_idx = 3'd1;
                            end else if (sel < 4'd12) begin
                                push         = 1'b1;
                                cmd.op       = sdio_pkg::OP_PAIRS;
                                cmd.tag      = sdio_pkg::pair_base(sel);
                                cmd.last_idx = (sel == sdio_pkg::SEL_QUAD) ? 3'd7 : 3'd1;
                            end
                        end
                        sdio_pkg::PORT_BALL: begin
                            ball_next = s_data[5:1];
                            wait_next = '0;
                        end
                        sdio_pkg::PORT_AUX5, sdio_pkg::PORT_AUX6: begin
                            wait_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
                sdio_pkg::KIND_READ: begin
                    push    = 1'b1;
                    cmd.tag = {3'b000, sdio_pkg::EV_READ};
                    cmd.a   = {|(latch_reg & slot3_reg), |(latch_reg & slot2_reg),
                               s_switches};
                end
                sdio_pkg::KIND_TICK: begin
                    phase_next   = phase_reg + 2'd1;
                    push         = 1'b1;
                    cmd.op       = sdio_pkg::OP_TICK;
                    cmd.tag      = {4'b0000, phase_next};
                    cmd.last_idx = phase_next[1] ? 3'd1 : 3'd2;
                    cmd.a        = {3'b000, ~ball_reg};
                    cmd.b        = {1'b0, match_reg};
                end
                sdio_pkg::KIND_POLL: begin
                    push    = 1'b1;
                    cmd.tag = {3'b000, sdio_pkg::EV_WAIT};
                    if (wait_reg < WAIT_LIMIT) begin
                        wait_next = wait_reg + 1'b1;
                        cmd.a     = 8'd0;
                    end else begin
                        cmd.a     = 8'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot2_reg <= sdio_pkg::CFG_SLOT2_RST;
            slot3_reg <= sdio_pkg::CFG_SLOT3_RST;
            latch_reg <= '0;
            match_reg <= '0;
            ball_reg  <= '0;
            phase_reg <= '0;
            wait_reg  <= WAIT_LIMIT;
        end else begin
            latch_reg <= latch_next;
            match_reg <= match_next;
            ball_reg  <= ball_next;
            phase_reg <= phase_next;
            wait_reg  <= wait_next;
            if (cfg_valid) begin
                case (cfg_index)
                    sdio_pkg::CFG_SLOT2: slot2_reg <= cfg_data;
                    sdio_pkg::CFG_SLOT3: slot3_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/sdio_cmdq.sv */
// Short command queue between the front and back ends.
// Depends on sdio_pkg and the assertion macro header.
`default_nettype none
`include "segment_display_io_board_core_macros.svh"

module sdio_cmdq #(
    parameter int DEPTH = 4
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  sdio_pkg::cmd_t       wr_cmd,
    output logic                 full,
    input  wire logic            pop,
    output logic                 rd_valid,
    output sdio_pkg::cmd_t       rd_cmd
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    sdio_pkg::cmd_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full     = (count_reg == CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `SDIO_ASSERT(a_pop_nonempty, aclk, aresetn, !pop || rd_valid, "pop from empty queue")
    `SDIO_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CW'(DEPTH), "queue overfilled")
    `SDIO_ASSERT_NEXT(a_count_up, aclk, aresetn, push && !pop,
        count_reg == $past(count_reg) + 1'b1, "queue count did not advance")

endmodule

`default_nettype wire

/* rtl/core/sdio_back.sv */
// Back end: expands queued commands into result transactions, one per cycle unless the output stalls.
// Depends on sdio_pkg and the assertion macro header.
`default_nettype none
`include "segment_display_io_board_core_macros.svh"

module sdio_back (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    input  sdio_pkg::cmd_t   q_cmd,
    output logic             q_pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_event,
    output logic [5:0]       m_position,
    output logic [7:0]       m_value,
    output logic             m_last
);

    sdio_pkg::cmd_t cur_reg;
    logic           cur_valid_reg;
    logic [2:0]     idx_reg;
    logic           out_valid_reg;
    logic [2:0]     out_event_reg;
    logic [5:0]     out_pos_reg;
    logic [7:0]     out_value_reg;
    logic           out_last_reg;

    logic           advance, fin;
    sdio_pkg::ev_t  r_event;
    logic [5:0]     r_pos;
    logic [7:0]     r_value;
    logic [5:0]     grp_off;
    logic [2:0]     player, pl_m1;
    logic [3:0]     lamp_mask;
    logic [7:0]     tone;

    assign advance = cur_valid_reg && (!out_valid_reg || m_ready);
    assign fin     = (idx_reg == cur_reg.last_idx);
    assign q_pop   = q_valid && (!cur_valid_reg || (advance && fin));

    // Result for the current command at the current index
    always_comb begin
        grp_off   = ({4'b0000, idx_reg[2:1]} << 3) + ({4'b0000, idx_reg[2:1]} << 1);
        player    = cur_reg.a[7:5];
        pl_m1     = player - 3'd1;
        lamp_mask = 4'hf;
        if (player >= 3'd1 && player <= 3'd4) begin
            lamp_mask[pl_m1[1:0]] = 1'b0;
        end
        if (cur_reg.a[0]) begin
            tone = 8'd1;
        end else if (cur_reg.a[1]) begin
            tone = 8'd2;
        end else if (cur_reg.a[2]) begin
            tone = 8'd3;
        end else if (cur_reg.a[3]) begin
            tone = 8'd4;
        end else begin
            tone = 8'd0;
        end

        r_event = sdio_pkg::EV_DIGIT;
        r_pos   = 6'd0;
        r_value = 8'd0;
        case (cur_reg.op)
            sdio_pkg::OP_SINGLE: begin
                r_event = sdio_pkg::ev_t'(cur_reg.tag[2:0]);
                r_value = cur_reg.a;
            end
            sdio_pkg::OP_MATCH: begin
                if (idx_reg == 3'd0) begin
                    r_pos   = sdio_pkg::POS_MATCH_ONE;
                    r_value = cur_reg.a[0] ? sdio_pkg::seg7(4'd1) : 8'd0;
                end else begin
                    r_pos   = (idx_reg == 3'd1) ? sdio_pkg::POS_MATCH_TEN
                                                : sdio_pkg::POS_MATCH_TEN2;
                    r_value = cur_reg.a[1] ? sdio_pkg::seg7(4'd0) : 8'd0;
                end
            end
            sdio_pkg::OP_SAMPLE: begin
                r_event = sdio_pkg::EV_SAMPLE;
                r_value = (idx_reg == 3'd0 && cur_reg.a[6]) ? sdio_pkg::SAMPLE_OUTHOLE
                                                            : sdio_pkg::SAMPLE_KNOCKER;
            end
            sdio_pkg::OP_TONE: begin
                if (idx_reg == 3'd0) begin
                    r_event = sdio_pkg::EV_TONE;
                    r_value = tone;
                end else begin
                    r_event = sdio_pkg::EV_LAMPS;
                    r_value = {4'h0, lamp_mask};
                end
            end
            sdio_pkg::OP_PAIRS: begin
                r_pos   = cur_reg.tag + grp_off + {5'b00000, idx_reg[0]};
                r_value = idx_reg[0] ? sdio_pkg::seg7(cur_reg.a[3:0])
                                     : sdio_pkg::seg7(cur_reg.a[7:4]);
            end
            sdio_pkg::OP_TICK: begin
                if (idx_reg == 3'd0) begin
                    r_event = sdio_pkg::EV_CPU;
                    r_value = {6'b000000, cur_reg.tag[1:0]};
                end else if (idx_reg == 3'd1) begin
                    r_pos   = cur_reg.tag[1] ? sdio_pkg::POS_TICK_HI : sdio_pkg::POS_TICK_LO;
                    r_value = cur_reg.b;
                end else begin
                    r_event = sdio_pkg::EV_LEDS;
                    r_value = cur_reg.a;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end else if (advance) begin
                if (fin) begin
                    cur_valid_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_cmd;
        end
        if (advance) begin
            out_event_reg <= r_event;
            out_pos_reg   <= r_pos;
            out_value_reg <= r_value;
            out_last_reg  <= fin;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_event    = out_event_reg;
    assign m_position = out_pos_reg;
    assign m_value    = out_value_reg;
    assign m_last     = out_last_reg;

    `SDIO_ASSERT(a_idx_bound, aclk, aresetn, !cur_valid_reg || idx_reg <= cur_reg.last_idx,
        "result index past end of command")
    `SDIO_ASSERT_NEXT(a_idx_step, aclk, aresetn, advance && !fin && !q_pop,
        cur_valid_reg && idx_reg == $past(idx_reg) + 3'd1, "result index did not step")
    `SDIO_ASSERT_NEXT(a_done_idle, aclk, aresetn, advance && fin && !q_valid,
        !cur_valid_reg, "command still active after final result")

endmodule

`default_nettype wire

/* rtl/core/segment_display_io_board_core.sv */
// Top level of the display and I/O core of a pinball processor board.
// Depends on sdio_pkg, sdio_front, sdio_cmdq and sdio_back.
`default_nettype none

// Bus-side display and I/O glue. Each input transaction is a CPU port write, a
// port 7 read, a mains-crossing tick or a wait-line poll (s_tuser gives which).
// The front end takes one input per cycle whenever the command queue
// (CMDQ_DEPTH entries) has room, updates the segment latch, match pattern,
// ball lamps, tick phase and wait counter at once, and queues a command for
// anything that produces results. The back end turns each command into 1 to 8
// result transactions, one per cycle unless m_tready stalls them, through a
// registered output stage; a digit-select of the four-pair group gives 8 digit
// results, most other items give 1 to 3, and writes that only set a latch give
// none. Throughput is thus bounded by the result side at one result per cycle;
// an item's first result passes the queue, command and output registers. Ready
// on the input side drops only while the queue is full. The coin-dip registers
// may be written at any time through the cfg_ channel, which never stalls.

module segment_display_io_board_core #(
    parameter int WAIT_POLLS = 384,
    parameter int CMDQ_DEPTH = 4
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Input items
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [23:0]                    s_tdata,  // port[2:0], data[10:3], service_switches[16:11]
    input  wire logic [1:0]                     s_tuser,  // kind[1:0]
    // Result items
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [15:0]                         m_tdata,  // position[5:0], value[13:6]
    output logic [2:0]                          m_tuser,  // event_res[2:0]
    output logic                                m_tlast,
    // Configuration writes
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [sdio_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                     cfg_data
);

    logic           q_full, q_push, q_pop, q_valid;
    sdio_pkg::cmd_t front_cmd, q_cmd;
    logic [5:0]     res_pos;
    logic [7:0]     res_value;

    // Configuration writes are always accepted and land in the slot registers.
    assign cfg_ready = 1'b1;

    sdio_front #(
        .WAIT_POLLS (WAIT_POLLS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_kind     (s_tuser),
        .s_port     (s_tdata[2:0]),
        .s_data     (s_tdata[10:3]),
        .s_switches (s_tdata[16:11]),
        .q_full     (q_full),
        .s_ready    (s_tready),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (q_push),
        .cmd        (front_cmd)
    );

    // Decouple the front end from result back-pressure.
    sdio_cmdq #(
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_cmd   (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_cmd   (q_cmd)
    );

    sdio_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_event    (m_tuser),
        .m_position (res_pos),
        .m_value    (res_value),
        .m_last     (m_tlast)
    );

    // Pack the result payload, padding to whole bytes.
    assign m_tdata = {2'b00, res_value, res_pos};

endmodule

`default_nettype wire
